/* hdl/pfr_pkg.sv */
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types, codes and helpers for the pixel format to RGBA32 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YUV_SELECT   = 1'd1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // source pixel formats
  typedef enum logic [1:0] {
    FMT_16_555  = 2'd0,
    FMT_16_565  = 2'd1,
    FMT_24_BGR  = 2'd2,
    FMT_32_BGRA = 2'd3
  } fmt_t;

  // conversion path carried down the pipeline
  typedef enum logic [1:0] {
    PATH_DIRECT = 2'd0,
    PATH_YUV655 = 2'd1,
    PATH_YUV744 = 2'd2
  } path_t;

  // unpack stage result
  typedef struct packed {
    path_t              path;
    logic [31:0]        color;  // finished color on the direct path
    logic [7:0]         y;
    logic signed [8:0]  cu;     // centered chroma (655) or du (744)
    logic signed [8:0]  cv;     // centered chroma (655) or dv (744)
  } unpack_t;

  // product stage result
  typedef struct packed {
    path_t              path;
    logic [31:0]        color;
    logic [7:0]         y;
    logic signed [8:0]  cu;
    logic signed [8:0]  cv;
    logic signed [17:0] p_rv;   // 359 * v
    logic signed [17:0] p_gu;   // 88 * u
    logic signed [17:0] p_gv;   // 183 * v
    logic signed [17:0] p_bu;   // 454 * u
    logic signed [10:0] g744;   // green of the shift-based path
  } prod_t;

  // saturate a signed channel value to 0..255
  function automatic logic [7:0] clamp8(input logic signed [11:0] val);
    logic [7:0] res;
    if (val < 0) begin
      res = 8'd0;
    end else if (val > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = val[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hdl/pfr_unpack.sv */
// ----------------------------------------------------------------------------
// pfr_unpack
// First stage: splits the raw word into fields and finishes the direct paths.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_unpack
  import pfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_vld,
  input  wire logic [31:0] raw_pixel,
  input  wire fmt_t        fmt,
  input  wire logic        yuv_sel,
  output logic             vld_r,
  output unpack_t          data_r
);

  logic [15:0] h;
  unpack_t     data_nxt;
  logic [7:0]  u655;
  logic [7:0]  v655;

  assign h = raw_pixel[15:0];

  // widened 655 chroma, low bits replicated only below half scale
  assign u655 = {h[4:0], (h[4] ? 3'b000 : h[4:2])};
  assign v655 = {h[9:5], (h[9] ? 3'b000 : h[9:7])};

  // field decode and direct formats
  always_comb begin
    data_nxt       = '0;
    data_nxt.path  = PATH_DIRECT;
    case (fmt)
      FMT_16_555: begin
        if (yuv_sel) begin
          data_nxt.path = PATH_YUV744;
          // luma sits in bits 14:8, bit 15 is unused
          data_nxt.y    = {h[14:8], h[14]};
          data_nxt.cu   = {~h[3], h[2:0], 5'b0};
          data_nxt.cv   = {~h[7], h[6:4], 5'b0};
        end else begin
          data_nxt.color = {ALPHA_OPAQUE, h[4:0], 3'b0, h[9:5], 3'b0, h[14:10], 3'b0};
        end
      end
      FMT_16_565: begin
        if (yuv_sel) begin
          data_nxt.path = PATH_YUV655;
          data_nxt.y    = {h[15:10], h[15:14]};
          data_nxt.cu   = {~u655[7], ~u655[7], u655[6:0]};
          data_nxt.cv   = {~v655[7], ~v655[7], v655[6:0]};
        end else begin
          data_nxt.color = {ALPHA_OPAQUE, h[4:0], 3'b0, h[10:5], 2'b0, h[15:11], 3'b0};
        end
      end
      FMT_24_BGR: begin
        data_nxt.color = {ALPHA_OPAQUE, raw_pixel[7:0], raw_pixel[15:8], raw_pixel[23:16]};
      end
      default: begin
        data_nxt.color = {raw_pixel[31:24], raw_pixel[7:0], raw_pixel[15:8],
                          raw_pixel[23:16]};
      end
    endcase
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

/* hdl/pfr_mult.sv */
// ----------------------------------------------------------------------------
// pfr_mult
// Second stage: constant-coefficient products and the shift-based green.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_mult
  import pfr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_vld,
  input  wire unpack_t in_data,
  output logic         vld_r,
  output prod_t        data_r
);

  logic signed [17:0] u_ext;
  logic signed [17:0] v_ext;
  logic signed [9:0]  uv_sum;
  logic signed [9:0]  uv_q;
  prod_t              data_nxt;

  assign u_ext  = 18'(in_data.cu);
  assign v_ext  = 18'(in_data.cv);

  // floor((du + dv) / 4)
  assign uv_sum = 10'(in_data.cu) + 10'(in_data.cv);
  assign uv_q   = uv_sum >>> 2;

  always_comb begin
    data_nxt       = '0;
    data_nxt.path  = in_data.path;
    data_nxt.color = in_data.color;
    data_nxt.y     = in_data.y;
    data_nxt.cu    = in_data.cu;
    data_nxt.cv    = in_data.cv;
    data_nxt.p_rv  = v_ext * 18'sd359;
    data_nxt.p_gu  = u_ext * 18'sd88;
    data_nxt.p_gv  = v_ext * 18'sd183;
    data_nxt.p_bu  = u_ext * 18'sd454;
    data_nxt.g744  = $signed({3'b000, in_data.y}) - 11'(uv_q);
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

/* hdl/pfr_pack.sv */
// ----------------------------------------------------------------------------
// pfr_pack
// Third stage: channel sums, rounding, clamping and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_pack
  import pfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_vld,
  input  wire prod_t       in_data,
  output logic             out_strobe,
  output logic [31:0]      out_color
);

  logic signed [19:0] y_term;
  logic signed [19:0] r_sum;
  logic signed [19:0] g_sum;
  logic signed [19:0] b_sum;
  logic signed [11:0] r744;
  logic signed [11:0] g744;
  logic signed [11:0] b744;
  logic               strobe_r;
  logic [31:0]        color_r;
  logic [31:0]        color_nxt;

  // 655 path: 256y + products + 128, floored by 256
  assign y_term = $signed({4'b0000, in_data.y, 8'h80});
  assign r_sum  = y_term + 20'(in_data.p_rv);
  assign g_sum  = y_term - 20'(in_data.p_gu) - 20'(in_data.p_gv);
  assign b_sum  = y_term + 20'(in_data.p_bu);

  // 744 path: blue and red from green
  assign g744 = 12'(in_data.g744);
  assign b744 = g744 + 12'(in_data.cu);
  assign r744 = g744 + 12'(in_data.cv);

  always_comb begin
    case (in_data.path)
      PATH_YUV655: begin
        color_nxt = {ALPHA_OPAQUE, clamp8(12'(b_sum >>> 8)), clamp8(12'(g_sum >>> 8)),
                     clamp8(12'(r_sum >>> 8))};
      end
      PATH_YUV744: begin
        color_nxt = {ALPHA_OPAQUE, clamp8(b744), clamp8(g744), clamp8(r744)};
      end
      default: begin
        color_nxt = in_data.color;
      end
    endcase
  end

  // output register, one strobe per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    color_r <= color_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_color  = color_r;

endmodule

`default_nettype wire

/* hdl/pixel_format_to_rgba32_core.sv */
// ----------------------------------------------------------------------------
// pixel_format_to_rgba32_core
// Converts raw framebuffer pixels (RGB555/565, YUV744/655, BGR24, BGRA32)
// into RGBA32 colors through a three-stage pipeline.
//
//   channel  ports                          transfer when
//   input    start, busy, in_raw_pixel      start high and busy low
//   result   out_strobe, out_color          out_strobe high (one cycle)
//   config   cfg_we, cfg_index, cfg_data    cfg_we high
//
// One pixel enters every cycle; busy is always low.
// A pixel passes three registered stages in order: unpack, constant multiply,
// sum/clamp into the output register.
// Format and YUV select are sampled with each pixel at its transfer.
// Reset clears the stage valid bits and sets the format to 32-bit BGRA.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_format_to_rgba32_core
  import pfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [31:0]           in_raw_pixel,
  output logic                       out_strobe,
  output logic [31:0]                out_color,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  fmt_t    pixel_format_r;
  logic    yuv_select_r;
  logic    in_vld;
  logic    s1_vld;
  unpack_t s1_data;
  logic    s2_vld;
  prod_t   s2_data;

  assign busy   = 1'b0;
  assign in_vld = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= FMT_32_BGRA;
      yuv_select_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_FORMAT: pixel_format_r <= fmt_t'(cfg_data[1:0]);
        CFG_YUV_SELECT:   yuv_select_r   <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // stage 1: field decode
  pfr_unpack u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_vld),
    .raw_pixel (in_raw_pixel),
    .fmt       (pixel_format_r),
    .yuv_sel   (yuv_select_r),
    .vld_r     (s1_vld),
    .data_r    (s1_data)
  );

  // stage 2: products
  pfr_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s1_vld),
    .in_data (s1_data),
    .vld_r   (s2_vld),
    .data_r  (s2_data)
  );

  // stage 3: sums, clamp, output
  pfr_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (s2_vld),
    .in_data    (s2_data),
    .out_strobe (out_strobe),
    .out_color  (out_color)
  );

endmodule

`default_nettype wire
